@@ sv/ray_box_exit_step_core_assert.svh @@
// Assertion macros for the ray box exit step core.
// Included by ray_box_exit_step_core, the module that carries concurrent checks; no other dependencies.
`ifndef RAY_BOX_EXIT_STEP_CORE_ASSERT_SVH
`define RAY_BOX_EXIT_STEP_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define RBES_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define RBES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define RBES_ASSERT_IMPLY(label, clk, rst, ante, cons, msg)
`define RBES_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

@@ sv/rbes_pkg.sv @@
// Shared types, widths, exit codes and the arctangent table of the ray box exit step core.
// No dependencies.
package rbes_pkg;

   localparam int CoordWidth  = 32;
   localparam int AngleWidth  = 18;
   localparam int IndexWidth  = 16;
   localparam int LengthWidth = 33;
   localparam int AtanEntries = 24;
   localparam int QuotWidth   = 42;

   localparam logic [QuotWidth-1:0] FarLimit = 42'h100_0000_0000;

   localparam logic [1:0] SideRight  = 2'd0;
   localparam logic [1:0] SideTop    = 2'd1;
   localparam logic [1:0] SideBottom = 2'd2;

   typedef logic signed [CoordWidth-1:0] coord_type;
   typedef logic signed [IndexWidth-1:0] index_type;

   typedef struct packed {
      coord_type bottom;
      coord_type right;
      coord_type top;
      coord_type src_x;
      coord_type src_y;
      index_type column;
      index_type row;
   } geom_type;

   typedef struct packed {
      geom_type           geom;
      logic signed [32:0] cos_val;
      logic signed [32:0] sin_val;
      logic               base_zero;
   } slope_type;

   typedef struct packed {
      coord_type          src_x;
      coord_type          src_y;
      coord_type          right;
      coord_type          exit_y;
      logic [1:0]         side;
      logic               err;
      index_type          column;
      index_type          row;
      logic signed [32:0] sin_val;
   } cls_type;

   typedef struct packed {
      coord_type  exit_x;
      coord_type  exit_y;
      logic [1:0] side;
      logic       err;
      index_type  column;
      index_type  row;
   } exit_type;

   // round(atan(2^-i) * 2^30)
   function automatic logic [29:0] atan_q30(input int unsigned idx);
      logic [29:0] val;
      unique case (idx)
         0:       val = 30'd843314857;
         1:       val = 30'd497837829;
         2:       val = 30'd263043837;
         3:       val = 30'd133525159;
         4:       val = 30'd67021687;
         5:       val = 30'd33543516;
         6:       val = 30'd16775851;
         7:       val = 30'd8388437;
         8:       val = 30'd4194283;
         9:       val = 30'd2097149;
         10:      val = 30'd1048576;
         11:      val = 30'd524288;
         12:      val = 30'd262144;
         13:      val = 30'd131072;
         14:      val = 30'd65536;
         15:      val = 30'd32768;
         16:      val = 30'd16384;
         17:      val = 30'd8192;
         18:      val = 30'd4096;
         19:      val = 30'd2048;
         20:      val = 30'd1024;
         21:      val = 30'd512;
         22:      val = 30'd256;
         23:      val = 30'd128;
         default: val = 30'd0;
      endcase
      return val;
   endfunction

endpackage

@@ sv/ray_box_exit_step_core.sv @@
// Ray box exit step: one request per clock while no result waits untaken.
// The pipeline is the CORDIC stages (at most 24), two 44-stage dividers (right-edge height, then
// edge crossing), two 2-stage multipliers, three classify/exit stages and the 35-stage root
// unit; every stage advances together whenever the result register is empty or being taken.
// Coordinates are signed Q16.16, the angle signed Q2.16 radians; the box lower-left x is
// carried on the bus but does not enter the result.
`include "ray_box_exit_step_core_assert.svh"
module ray_box_exit_step_core #(
   parameter int TRIG_ITERATIONS = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // box_left_x, box_bottom_y, box_right_x, box_top_y, source_x, source_y (32 each),
   // ray_angle (18), cell_column (16), cell_row (16), zero pad (6)
   input  logic [247:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // exit_x (32), exit_y (32), path_length (33), next_column (16), next_row (16), zero pad (7)
   output logic [135:0] rsp_tdata,
   // exit_side (2), slope_error (1)
   output logic [2:0]   rsp_tuser
);
   import rbes_pkg::*;

   localparam int CordicSteps = (TRIG_ITERATIONS < AtanEntries) ? TRIG_ITERATIONS : AtanEntries;

   logic adv;

   geom_type                   in_geom;
   logic signed [AngleWidth-1:0] in_angle;

   logic                 c_valid;
   logic signed [32:0]   c_cos, c_sin;
   geom_type             c_geom;
   slope_type            c_slope;
   logic signed [32:0]   c_base;

   logic                 m1_valid;
   logic signed [65:0]   m1_prod;
   slope_type            m1_slope;

   logic                        d1_valid;
   logic signed [QuotWidth-1:0] d1_height;
   slope_type                   d1_slope;

   logic signed [42:0]   ty;
   logic [1:0]           side_sel;
   logic                 need_edge, err_sel;
   coord_type            edge_y, exit_y_sel;
   index_type            col_sel, row_sel;
   cls_type              cls_in, cls_ff;
   logic signed [32:0]   diff_in, diff_ff, cos_ff;
   logic                 cls_valid_ff;

   logic                 m2_valid;
   logic signed [65:0]   m2_prod;
   cls_type              m2_cls;

   logic                        d2_valid;
   logic signed [QuotWidth-1:0] d2_dx;
   cls_type                     d2_cls;

   logic signed [42:0]   cross_x;
   coord_type            clamp_x;
   exit_type             e1_in, e1_ff;
   coord_type            e1_src_x_ff, e1_src_y_ff;
   logic                 e1_valid_ff;

   logic signed [32:0]   dist_x, dist_y, abs_x, abs_y;
   logic [31:0]          e2_a_ff, e2_b_ff;
   exit_type             e2_ff;
   logic                 e2_valid_ff;

   logic                   sq_valid;
   logic [LengthWidth-1:0] sq_len;
   exit_type               sq_exit;

   // the whole pipeline holds while a result waits
   assign adv        = !rsp_tvalid || rsp_tready;
   assign req_tready = adv;

   assign in_geom.bottom = req_tdata[63:32];
   assign in_geom.right  = req_tdata[95:64];
   assign in_geom.top    = req_tdata[127:96];
   assign in_geom.src_x  = req_tdata[159:128];
   assign in_geom.src_y  = req_tdata[191:160];
   assign in_angle       = req_tdata[209:192];
   assign in_geom.column = req_tdata[225:210];
   assign in_geom.row    = req_tdata[241:226];

   rbes_cordic #(
      .Iterations (CordicSteps),
      .SideWidth  ($bits(geom_type))
   ) u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (req_tvalid && req_tready),
      .angle     (in_angle),
      .side_in   (in_geom),
      .out_valid (c_valid),
      .cos_out   (c_cos),
      .sin_out   (c_sin),
      .side_out  (c_geom)
   );

   assign c_base            = 33'(c_geom.right) - 33'(c_geom.src_x);
   assign c_slope.geom      = c_geom;
   assign c_slope.cos_val   = c_cos;
   assign c_slope.sin_val   = c_sin;
   assign c_slope.base_zero = (c_base == '0);

   rbes_mul #(
      .SideWidth ($bits(slope_type))
   ) u_mul_height (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (c_valid),
      .op_a      (c_base),
      .op_b      (c_sin),
      .side_in   (c_slope),
      .out_valid (m1_valid),
      .product   (m1_prod),
      .side_out  (m1_slope)
   );

   rbes_div #(
      .SideWidth ($bits(slope_type))
   ) u_div_height (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (m1_valid),
      .numer     (m1_prod),
      .denom     (m1_slope.cos_val),
      .side_in   (m1_slope),
      .out_valid (d1_valid),
      .quot      (d1_height),
      .side_out  (d1_slope)
   );

   // classify: top edge wins over bottom edge
   assign ty = 43'(d1_slope.geom.src_y) + 43'(d1_height);

   always_comb begin
      priority if (ty > 43'(d1_slope.geom.top)) begin
         side_sel = SideTop;
      end else if (ty < 43'(d1_slope.geom.bottom)) begin
         side_sel = SideBottom;
      end else begin
         side_sel = SideRight;
      end
   end

   assign need_edge = (side_sel != SideRight);
   assign err_sel   = need_edge && ((d1_slope.sin_val == '0) || d1_slope.base_zero);
   assign edge_y    = (side_sel == SideTop) ? d1_slope.geom.top : d1_slope.geom.bottom;
   assign diff_in   = 33'(edge_y) - 33'(d1_slope.geom.src_y);

   always_comb begin
      col_sel    = d1_slope.geom.column;
      row_sel    = d1_slope.geom.row;
      exit_y_sel = edge_y;
      if (err_sel) begin
         exit_y_sel = '0;
      end else begin
         unique case (side_sel)
            SideRight: begin
               exit_y_sel = ty[CoordWidth-1:0];
               if (d1_slope.geom.column != 16'sh7fff) begin
                  col_sel = d1_slope.geom.column + 16'sd1;
               end
            end
            SideTop: begin
               if (d1_slope.geom.row != 16'sh7fff) begin
                  row_sel = d1_slope.geom.row + 16'sd1;
               end
            end
            SideBottom: begin
               if (d1_slope.geom.row != -16'sh8000) begin
                  row_sel = d1_slope.geom.row - 16'sd1;
               end
            end
            default: begin
               exit_y_sel = edge_y;
            end
         endcase
      end
   end

   assign cls_in.src_x   = d1_slope.geom.src_x;
   assign cls_in.src_y   = d1_slope.geom.src_y;
   assign cls_in.right   = d1_slope.geom.right;
   assign cls_in.exit_y  = exit_y_sel;
   assign cls_in.side    = side_sel;
   assign cls_in.err     = err_sel;
   assign cls_in.column  = col_sel;
   assign cls_in.row     = row_sel;
   assign cls_in.sin_val = d1_slope.sin_val;

   always_ff @(posedge clock) begin
      if (reset) begin
         cls_valid_ff <= 1'b0;
      end else if (adv) begin
         cls_valid_ff <= d1_valid;
      end
      if (adv) begin
         cls_ff  <= cls_in;
         diff_ff <= diff_in;
         cos_ff  <= d1_slope.cos_val;
      end
   end

   rbes_mul #(
      .SideWidth ($bits(cls_type))
   ) u_mul_cross (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (cls_valid_ff),
      .op_a      (diff_ff),
      .op_b      (cos_ff),
      .side_in   (cls_ff),
      .out_valid (m2_valid),
      .product   (m2_prod),
      .side_out  (m2_cls)
   );

   rbes_div #(
      .SideWidth ($bits(cls_type))
   ) u_div_cross (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (m2_valid),
      .numer     (m2_prod),
      .denom     (m2_cls.sin_val),
      .side_in   (m2_cls),
      .out_valid (d2_valid),
      .quot      (d2_dx),
      .side_out  (d2_cls)
   );

   // exit point: saturate the edge crossing to the coordinate range
   assign cross_x = 43'(d2_cls.src_x) + 43'(d2_dx);

   always_comb begin
      if (cross_x > 43'sh000_7fff_ffff) begin
         clamp_x = 32'sh7fff_ffff;
      end else if (cross_x < -43'sh000_8000_0000) begin
         clamp_x = -32'sh8000_0000;
      end else begin
         clamp_x = cross_x[CoordWidth-1:0];
      end
   end

   always_comb begin
      e1_in.exit_y = d2_cls.exit_y;
      e1_in.side   = d2_cls.side;
      e1_in.err    = d2_cls.err;
      e1_in.column = d2_cls.column;
      e1_in.row    = d2_cls.row;
      priority if (d2_cls.err) begin
         e1_in.exit_x = '0;
      end else if (d2_cls.side == SideRight) begin
         e1_in.exit_x = d2_cls.right;
      end else begin
         e1_in.exit_x = clamp_x;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         e1_valid_ff <= 1'b0;
      end else if (adv) begin
         e1_valid_ff <= d2_valid;
      end
      if (adv) begin
         e1_ff       <= e1_in;
         e1_src_x_ff <= d2_cls.src_x;
         e1_src_y_ff <= d2_cls.src_y;
      end
   end

   assign dist_x = 33'(e1_ff.exit_x) - 33'(e1_src_x_ff);
   assign dist_y = 33'(e1_ff.exit_y) - 33'(e1_src_y_ff);
   assign abs_x  = dist_x[32] ? -dist_x : dist_x;
   assign abs_y  = dist_y[32] ? -dist_y : dist_y;

   // drop the distance on a slope error
   always_ff @(posedge clock) begin
      if (reset) begin
         e2_valid_ff <= 1'b0;
      end else if (adv) begin
         e2_valid_ff <= e1_valid_ff;
      end
      if (adv) begin
         e2_a_ff <= e1_ff.err ? '0 : abs_x[31:0];
         e2_b_ff <= e1_ff.err ? '0 : abs_y[31:0];
         e2_ff   <= e1_ff;
      end
   end

   rbes_sqrt #(
      .SideWidth ($bits(exit_type))
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (e2_valid_ff),
      .mag_a     (e2_a_ff),
      .mag_b     (e2_b_ff),
      .side_in   (e2_ff),
      .out_valid (sq_valid),
      .root      (sq_len),
      .side_out  (sq_exit)
   );

   assign rsp_tvalid = sq_valid;
   assign rsp_tdata  = {7'd0, sq_exit.row, sq_exit.column, sq_len, sq_exit.exit_y,
                        sq_exit.exit_x};
   assign rsp_tuser  = {sq_exit.err, sq_exit.side};

   `RBES_ASSERT_IMPLY(a_err_zero, clock, reset, rsp_tvalid && sq_exit.err, (sq_exit.exit_x == '0) && (sq_exit.exit_y == '0) && (sq_len == '0), "slope error with nonzero result")
   `RBES_ASSERT_IMPLY(a_side_code, clock, reset, rsp_tvalid, (sq_exit.side == SideRight) || (sq_exit.side == SideTop) || (sq_exit.side == SideBottom), "exit side out of range")
   `RBES_ASSERT_IMPLY(a_right_no_err, clock, reset, cls_valid_ff && (cls_ff.side == SideRight), !cls_ff.err, "right exit flagged as slope error")
   `RBES_ASSERT_NEXT(a_stall_hold, clock, reset, !adv, $stable(cls_valid_ff) && $stable(e2_valid_ff), "pipeline moved during stall")

endmodule

@@ sv/rbes_cordic.sv @@
// Pipelined rotation-mode CORDIC: one micro-rotation per register stage.
// Depends on rbes_pkg for the arctangent table.
module rbes_cordic #(
   parameter int Iterations = 16,
   parameter int SideWidth  = 1
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 en,
   input  logic                                 in_valid,
   input  logic signed [rbes_pkg::AngleWidth-1:0] angle,
   input  logic [SideWidth-1:0]                 side_in,
   output logic                                 out_valid,
   output logic signed [32:0]                   cos_out,
   output logic signed [32:0]                   sin_out,
   output logic [SideWidth-1:0]                 side_out
);
   import rbes_pkg::*;

   localparam int ZWidth = 34;

   logic signed [32:0]       cx_ff    [Iterations];
   logic signed [32:0]       cy_ff    [Iterations];
   logic signed [ZWidth-1:0] z_ff     [Iterations];
   logic                     valid_ff [Iterations];
   logic [SideWidth-1:0]     side_ff  [Iterations];

   for (genvar i = 0; i < Iterations; i++) begin : g_iter
      logic signed [32:0]       cx_prev, cy_prev, xs, ys, cx_in, cy_in;
      logic signed [ZWidth-1:0] z_prev, z_in, step;
      logic                     valid_prev;
      logic [SideWidth-1:0]     side_prev;

      if (i == 0) begin : g_first
         assign cx_prev    = 33'sh0_4000_0000;
         assign cy_prev    = '0;
         assign z_prev     = ZWidth'(angle) <<< 14;
         assign valid_prev = in_valid;
         assign side_prev  = side_in;
      end else begin : g_next
         assign cx_prev    = cx_ff[i-1];
         assign cy_prev    = cy_ff[i-1];
         assign z_prev     = z_ff[i-1];
         assign valid_prev = valid_ff[i-1];
         assign side_prev  = side_ff[i-1];
      end

      assign xs   = cx_prev >>> i;
      assign ys   = cy_prev >>> i;
      assign step = ZWidth'(atan_q30(i));

      always_comb begin
         if (!z_prev[ZWidth-1]) begin
            cx_in = cx_prev - ys;
            cy_in = cy_prev + xs;
            z_in  = z_prev - step;
         end else begin
            cx_in = cx_prev + ys;
            cy_in = cy_prev - xs;
            z_in  = z_prev + step;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[i] <= 1'b0;
         end else if (en) begin
            valid_ff[i] <= valid_prev;
         end
         if (en) begin
            cx_ff[i]   <= cx_in;
            cy_ff[i]   <= cy_in;
            z_ff[i]    <= z_in;
            side_ff[i] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[Iterations-1];
   assign cos_out   = cx_ff[Iterations-1];
   assign sin_out   = cy_ff[Iterations-1];
   assign side_out  = side_ff[Iterations-1];

endmodule

@@ sv/rbes_mul.sv @@
// Two-stage signed 33 x 33 multiplier built from two registered 33 x 17 partial products.
// Depends on no other module.
module rbes_mul #(
   parameter int SideWidth = 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  logic signed [32:0]   op_a,
   input  logic signed [32:0]   op_b,
   input  logic [SideWidth-1:0] side_in,
   output logic                 out_valid,
   output logic signed [65:0]   product,
   output logic [SideWidth-1:0] side_out
);
   logic signed [49:0]   pp_lo_in, pp_hi_in, pp_lo_ff, pp_hi_ff;
   logic                 pp_valid_ff, out_valid_ff;
   logic [SideWidth-1:0] pp_side_ff, out_side_ff;
   logic signed [65:0]   product_in, product_ff;

   assign pp_lo_in   = op_a * $signed({1'b0, op_b[15:0]});
   assign pp_hi_in   = op_a * $signed(op_b[32:16]);
   assign product_in = (66'(pp_hi_ff) <<< 16) + 66'(pp_lo_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         pp_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (en) begin
         pp_valid_ff  <= in_valid;
         out_valid_ff <= pp_valid_ff;
      end
      if (en) begin
         pp_lo_ff    <= pp_lo_in;
         pp_hi_ff    <= pp_hi_in;
         pp_side_ff  <= side_in;
         product_ff  <= product_in;
         out_side_ff <= pp_side_ff;
      end
   end

   assign out_valid = out_valid_ff;
   assign product   = product_ff;
   assign side_out  = out_side_ff;

endmodule

@@ sv/rbes_div.sv @@
// Pipelined truncating signed divider, one quotient bit per stage, clamped to +-2^40.
// Depends on rbes_pkg for the quotient width and the clamp limit.
module rbes_div #(
   parameter int SideWidth = 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic signed [65:0]                  numer,
   input  logic signed [32:0]                  denom,
   input  logic [SideWidth-1:0]                side_in,
   output logic                                out_valid,
   output logic signed [rbes_pkg::QuotWidth-1:0] quot,
   output logic [SideWidth-1:0]                side_out
);
   import rbes_pkg::*;

   localparam int Steps = QuotWidth;

   logic [65:0] num_abs;
   logic [63:0] num_mag;
   logic [32:0] den_abs;
   logic        ovf_in;

   logic                 pre_valid_ff, pre_neg_ff, pre_ovf_ff;
   logic [32:0]          pre_rem_ff, pre_den_ff;
   logic [Steps-1:0]     pre_low_ff;
   logic [SideWidth-1:0] pre_side_ff;

   logic [32:0]          rem_ff   [Steps];
   logic [32:0]          den_ff   [Steps];
   logic [Steps-1:0]     low_ff   [Steps];
   logic [Steps-1:0]     q_ff     [Steps];
   logic                 neg_ff   [Steps];
   logic                 ovf_ff   [Steps];
   logic                 valid_ff [Steps];
   logic [SideWidth-1:0] side_ff  [Steps];

   logic [Steps-1:0]            mag;
   logic signed [Steps-1:0]     res_in, res_ff;
   logic                        res_valid_ff;
   logic [SideWidth-1:0]        res_side_ff;

   assign num_abs = numer[65] ? -numer : numer;
   assign num_mag = num_abs[63:0];
   assign den_abs = denom[32] ? -denom : denom;
   // a zero divisor with a nonzero dividend lands here too and saturates
   assign ovf_in  = (num_mag != '0) && (33'(num_mag[63:Steps]) >= den_abs);

   always_ff @(posedge clock) begin
      if (reset) begin
         pre_valid_ff <= 1'b0;
      end else if (en) begin
         pre_valid_ff <= in_valid;
      end
      if (en) begin
         pre_rem_ff  <= 33'(num_mag[63:Steps]);
         pre_low_ff  <= num_mag[Steps-1:0];
         // zero over zero: divide by one so the quotient comes out as zero
         pre_den_ff  <= (den_abs == '0) ? 33'd1 : den_abs;
         pre_neg_ff  <= numer[65] ^ denom[32];
         pre_ovf_ff  <= ovf_in;
         pre_side_ff <= side_in;
      end
   end

   for (genvar j = 0; j < Steps; j++) begin : g_step
      logic [32:0]          rem_prev, den_prev, rem_in;
      logic [Steps-1:0]     low_prev, q_prev;
      logic                 neg_prev, ovf_prev, valid_prev, fits;
      logic [SideWidth-1:0] side_prev;
      logic [33:0]          trial;

      if (j == 0) begin : g_first
         assign rem_prev   = pre_rem_ff;
         assign den_prev   = pre_den_ff;
         assign low_prev   = pre_low_ff;
         assign q_prev     = '0;
         assign neg_prev   = pre_neg_ff;
         assign ovf_prev   = pre_ovf_ff;
         assign valid_prev = pre_valid_ff;
         assign side_prev  = pre_side_ff;
      end else begin : g_next
         assign rem_prev   = rem_ff[j-1];
         assign den_prev   = den_ff[j-1];
         assign low_prev   = low_ff[j-1];
         assign q_prev     = q_ff[j-1];
         assign neg_prev   = neg_ff[j-1];
         assign ovf_prev   = ovf_ff[j-1];
         assign valid_prev = valid_ff[j-1];
         assign side_prev  = side_ff[j-1];
      end

      assign trial  = {rem_prev, low_prev[Steps-1]};
      assign fits   = trial >= {1'b0, den_prev};
      assign rem_in = fits ? 33'(trial - {1'b0, den_prev}) : trial[32:0];

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[j] <= 1'b0;
         end else if (en) begin
            valid_ff[j] <= valid_prev;
         end
         if (en) begin
            rem_ff[j]  <= rem_in;
            den_ff[j]  <= den_prev;
            low_ff[j]  <= low_prev << 1;
            q_ff[j]    <= {q_prev[Steps-2:0], fits};
            neg_ff[j]  <= neg_prev;
            ovf_ff[j]  <= ovf_prev;
            side_ff[j] <= side_prev;
         end
      end
   end

   assign mag    = (ovf_ff[Steps-1] || (q_ff[Steps-1] > FarLimit)) ? FarLimit : q_ff[Steps-1];
   assign res_in = neg_ff[Steps-1] ? -$signed(mag) : $signed(mag);

   always_ff @(posedge clock) begin
      if (reset) begin
         res_valid_ff <= 1'b0;
      end else if (en) begin
         res_valid_ff <= valid_ff[Steps-1];
      end
      if (en) begin
         res_ff      <= res_in;
         res_side_ff <= side_ff[Steps-1];
      end
   end

   assign out_valid = res_valid_ff;
   assign quot      = res_ff;
   assign side_out  = res_side_ff;

endmodule

@@ sv/rbes_sqrt.sv @@
// Pipelined floor(sqrt(a^2 + b^2)): squares, sum, then one root bit per stage.
// Depends on rbes_pkg for the length width.
module rbes_sqrt #(
   parameter int SideWidth = 1
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                en,
   input  logic                                in_valid,
   input  logic [31:0]                         mag_a,
   input  logic [31:0]                         mag_b,
   input  logic [SideWidth-1:0]                side_in,
   output logic                                out_valid,
   output logic [rbes_pkg::LengthWidth-1:0]    root,
   output logic [SideWidth-1:0]                side_out
);
   import rbes_pkg::*;

   localparam int Bits = LengthWidth;
   localparam int RemWidth = 67;

   logic [63:0]          sq_a_ff, sq_b_ff;
   logic                 sq_valid_ff, sum_valid_ff;
   logic [SideWidth-1:0] sq_side_ff, sum_side_ff;
   logic [RemWidth-1:0]  sum_ff;

   logic [RemWidth-1:0]  rem_ff   [Bits];
   logic [Bits-1:0]      root_ff  [Bits];
   logic                 valid_ff [Bits];
   logic [SideWidth-1:0] side_ff  [Bits];

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else if (en) begin
         sq_valid_ff  <= in_valid;
         sum_valid_ff <= sq_valid_ff;
      end
      if (en) begin
         sq_a_ff     <= mag_a * mag_a;
         sq_b_ff     <= mag_b * mag_b;
         sq_side_ff  <= side_in;
         sum_ff      <= RemWidth'(sq_a_ff) + RemWidth'(sq_b_ff);
         sum_side_ff <= sq_side_ff;
      end
   end

   // stage k decides root bit Bits-1-k
   for (genvar k = 0; k < Bits; k++) begin : g_bit
      localparam int B = Bits - 1 - k;
      logic [RemWidth-1:0]  rem_prev, trial;
      logic [Bits-1:0]      root_prev;
      logic                 valid_prev, take;
      logic [SideWidth-1:0] side_prev;

      if (k == 0) begin : g_first
         assign rem_prev   = sum_ff;
         assign root_prev  = '0;
         assign valid_prev = sum_valid_ff;
         assign side_prev  = sum_side_ff;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign valid_prev = valid_ff[k-1];
         assign side_prev  = side_ff[k-1];
      end

      assign trial = (RemWidth'(root_prev) << (B + 1)) | (RemWidth'(1) << (2 * B));
      assign take  = rem_prev >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
         if (en) begin
            rem_ff[k]  <= take ? rem_prev - trial : rem_prev;
            root_ff[k] <= take ? (root_prev | (Bits'(1) << B)) : root_prev;
            side_ff[k] <= side_prev;
         end
      end
   end

   assign out_valid = valid_ff[Bits-1];
   assign root      = root_ff[Bits-1];
   assign side_out  = side_ff[Bits-1];

endmodule
